// File: design/srsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed ramp servo drive package
// Shared types, command codes, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package srsd_pkg;

	localparam int SPEED_W   = 18;
	localparam int MUL_A_W   = 23;
	localparam int MUL_B_W   = 24;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int PADDR_W   = 5;
	localparam int IN_DATA_W = 120;
	localparam int OUT_DATA_W = 16;

	typedef logic signed [SPEED_W-1:0] speed_t;

	localparam speed_t SPEED_LIMIT = 18'sd100000;
	localparam speed_t MILLI_PER_UNIT = 18'sd1000;
	localparam speed_t STICK_SCALE = 18'sd100;
	localparam logic [7:0] REQ_LIMIT = 8'd100;
	localparam logic [7:0] SPAN_STEP = 8'd20;
	localparam logic [31:0] MS_PER_S = 32'd1000;

	// floor(u / 5000) = (u * DIV5000_M) >> 35 for u < 2^22
	localparam logic [23:0] ANGLE_BIAS = 24'd1000000;
	localparam logic signed [11:0] ANGLE_BIAS_Q = 12'sd200;
	localparam logic [23:0] ANGLE_DIVISOR = 24'd5000;
	localparam logic [22:0] DIV5000_M = 23'd6871948;
	// floor(a / 1000) = (a * DIV1000_M) >> 27 for a < 2^17
	localparam logic [17:0] DIV1000_M = 18'd134218;

	typedef enum logic [2:0] {
		FN_TICK  = 3'd0,
		FN_SET   = 3'd1,
		FN_TIMED = 3'd2,
		FN_STOP  = 3'd3,
		FN_INIT  = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		REG_CENTER   = 3'd0,
		REG_FLOOR    = 3'd1,
		REG_CEILING  = 3'd2,
		REG_SPAN     = 3'd3,
		REG_ACCEL    = 3'd4,
		REG_DECEL    = 3'd5,
		REG_WANDER   = 3'd6,
		REG_DELAY    = 3'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CMD,
		ST_RAMP_MUL,
		ST_RAMP_ADD,
		ST_ANG_MUL,
		ST_ANG_CEN,
		ST_ANG_SUM,
		ST_ANG_DIV,
		ST_SPD_DIV,
		ST_DONE
	} st_t;

	typedef struct packed {
		logic [7:0] center;
		logic [7:0] floor_angle;
		logic [7:0] ceil_angle;
		logic [2:0] span;
		logic [9:0] accel;
		logic [9:0] decel;
		logic       wander_en;
		logic [7:0] first_delay;
	} srsd_cfg_t;

endpackage

// File: design/srsd_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed multiply with a registered product, loaded only when issued.
// ----------------------------------------------------------------------------
module srsd_mul
	import srsd_pkg::*;
(
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic signed [MUL_B_W-1:0] b,
	output logic signed [MUL_P_W-1:0] p_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= a * b;
		end
	end

endmodule

// File: design/srsd_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file for center, angle limits, span, slew rates, wander and first delay.
// ----------------------------------------------------------------------------
module srsd_regs
	import srsd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output srsd_cfg_t          cfg
);

	srsd_cfg_t cfg_q;
	logic      wr_en;
	reg_idx_t  idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[4:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center      <= 8'd90;
			cfg_q.floor_angle <= 8'd0;
			cfg_q.ceil_angle  <= 8'd180;
			cfg_q.span        <= 3'd3;
			cfg_q.accel       <= 10'd100;
			cfg_q.decel       <= 10'd100;
			cfg_q.wander_en   <= 1'b0;
			cfg_q.first_delay <= 8'd5;
		end else if (wr_en) begin
			unique case (idx)
				REG_CENTER:  cfg_q.center      <= pwdata[7:0];
				REG_FLOOR:   cfg_q.floor_angle <= pwdata[7:0];
				REG_CEILING: cfg_q.ceil_angle  <= pwdata[7:0];
				REG_SPAN:    cfg_q.span        <= pwdata[2:0];
				REG_ACCEL:   cfg_q.accel       <= pwdata[9:0];
				REG_DECEL:   cfg_q.decel       <= pwdata[9:0];
				REG_WANDER:  cfg_q.wander_en   <= pwdata[0];
				REG_DELAY:   cfg_q.first_delay <= pwdata[7:0];
				default:     cfg_q.center      <= cfg_q.center;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_CENTER:  prdata = {24'd0, cfg_q.center};
			REG_FLOOR:   prdata = {24'd0, cfg_q.floor_angle};
			REG_CEILING: prdata = {24'd0, cfg_q.ceil_angle};
			REG_SPAN:    prdata = {29'd0, cfg_q.span};
			REG_ACCEL:   prdata = {22'd0, cfg_q.accel};
			REG_DECEL:   prdata = {22'd0, cfg_q.decel};
			REG_WANDER:  prdata = {31'd0, cfg_q.wander_en};
			REG_DELAY:   prdata = {24'd0, cfg_q.first_delay};
			default:     prdata = 32'd0;
		endcase
	end

endmodule

// File: design/speed_ramp_servo_drive.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed ramp servo drive
// Ramps motor speed toward a target with separate accel and decel slew rates
// and returns the servo angle and integer speed for every command item.
// ----------------------------------------------------------------------------
// An item runs through ST_CMD, then ST_RAMP_MUL and ST_RAMP_ADD on a tick that
// ramps, then ST_ANG_MUL, ST_ANG_CEN, ST_ANG_SUM, ST_ANG_DIV, ST_SPD_DIV and
// ST_DONE; the next item is taken the cycle after the result register loads.
// The sequencer uses one shared 23x24 multiplier in turn for the ramp step,
// the angle product, the angle offset and the two reciprocal divides. A finished
// result waits in an output register, so the next item can be accepted while it
// is still pending.
// ----------------------------------------------------------------------------
module speed_ramp_servo_drive
	import srsd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// stream in
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// now_ms[31:0], speed_request[47:32], duration_ms[71:48], halt[72],
	// stationary_mode[73], scene_active[74], stick_value[85:75],
	// random_target[93:86], random_wait_ms[113:94], zero pad[119:114]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// func[2:0]
	input  logic [2:0]            s_tuser,
	// stream out
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// servo_angle[7:0], speed_now[15:8]
	output logic [OUT_DATA_W-1:0] m_tdata,
	// configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	srsd_cfg_t cfg;

	st_t st_q, st_d;

	// latched item
	logic [2:0]         in_func_q;
	logic [31:0]        in_now_q;
	logic signed [15:0] in_req_q;
	logic [23:0]        in_dur_q;
	logic               in_halt_q;
	logic               in_stat_q;
	logic               in_scene_q;
	logic signed [10:0] in_stick_q;
	logic signed [7:0]  in_rand_q;
	logic [19:0]        in_wait_q;

	// motor state
	speed_t      present_q;
	speed_t      goal_q;
	logic [31:0] last_tick_q;
	logic [31:0] wander_due_q;
	logic [31:0] timed_end_q;
	logic        timed_active_q;

	// work registers
	logic [15:0] dt_q;
	logic [21:0] acc_q;
	logic [7:0]  angle_q;
	logic        m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	// shared multiplier
	logic                      mul_en;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] prod_q;

	logic in_accept, out_free, out_load;

	// tick decode
	logic [31:0]       elapsed;
	logic [15:0]       dt_sat;
	logic [31:0]       timed_diff;
	logic [31:0]       wander_diff;
	logic              timed_hit;
	logic              wander_hit;
	logic              follow;
	logic signed [7:0] req_s8;
	speed_t            req_goal;
	speed_t            stick_goal_raw;
	speed_t            stick_goal;
	logic [7:0]        range8;
	logic signed [8:0] range9;
	logic signed [8:0] rand9;
	logic signed [8:0] rand_rng;
	logic signed [7:0] rand_s8;
	speed_t            rand_goal;
	logic [31:0]       wander_next;
	logic [31:0]       init_due;
	logic [31:0]       timed_end_next;

	// ramp
	logic               ramp_up;
	logic               ramp_dn;
	logic [9:0]         rate_sel;
	logic signed [27:0] pres28;
	logic signed [27:0] goal28;
	logic signed [27:0] step28;
	logic signed [27:0] ramp_sum;
	speed_t             ramp_next;

	// result
	logic [23:0]        acc_seed;
	logic signed [11:0] q12;
	logic signed [11:0] floor12;
	logic signed [11:0] ceil12;
	logic signed [11:0] q_clamp;
	speed_t             pres_neg;
	logic [16:0]        pres_abs;
	logic [7:0]         spd_mag;
	logic [7:0]         speed_now;

	srsd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	srsd_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod_q)
	);

	assign s_tready  = (st_q == ST_IDLE);
	assign in_accept = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign out_load  = (st_q == ST_DONE) && out_free;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// tick decode
	always_comb begin
		elapsed     = in_now_q - last_tick_q;
		dt_sat      = (elapsed > 32'd65535) ? 16'hFFFF : elapsed[15:0];
		timed_diff  = in_now_q - timed_end_q;
		wander_diff = in_now_q - wander_due_q;
		timed_hit   = timed_active_q && !timed_diff[31];
		wander_hit  = cfg.wander_en && !wander_diff[31];
		follow      = in_stat_q && !cfg.wander_en && !in_scene_q;

		if (in_req_q > 16'sd100) begin
			req_s8 = 8'sd100;
		end else if (in_req_q < -16'sd100) begin
			req_s8 = -8'sd100;
		end else begin
			req_s8 = in_req_q[7:0];
		end
		req_goal = SPEED_W'(req_s8) * MILLI_PER_UNIT;

		stick_goal_raw = SPEED_W'(in_stick_q) * STICK_SCALE;
		if (stick_goal_raw > SPEED_LIMIT) begin
			stick_goal = SPEED_LIMIT;
		end else if (stick_goal_raw < -SPEED_LIMIT) begin
			stick_goal = -SPEED_LIMIT;
		end else begin
			stick_goal = stick_goal_raw;
		end

		range8 = 8'(cfg.span) * SPAN_STEP;
		range9 = signed'({1'b0, range8});
		rand9  = 9'(in_rand_q);
		if (rand9 > range9) begin
			rand_rng = range9;
		end else if (rand9 < -range9) begin
			rand_rng = -range9;
		end else begin
			rand_rng = rand9;
		end
		if (rand_rng > 9'sd100) begin
			rand_s8 = 8'sd100;
		end else if (rand_rng < -9'sd100) begin
			rand_s8 = -8'sd100;
		end else begin
			rand_s8 = rand_rng[7:0];
		end
		rand_goal = SPEED_W'(rand_s8) * MILLI_PER_UNIT;

		wander_next    = in_now_q + 32'(in_wait_q);
		init_due       = in_now_q + 32'(cfg.first_delay) * MS_PER_S;
		timed_end_next = in_now_q + 32'(in_dur_q);
	end

	// ramp
	always_comb begin
		ramp_up  = present_q < goal_q;
		ramp_dn  = present_q > goal_q;
		rate_sel = ramp_up ? cfg.accel : cfg.decel;
		pres28   = 28'(present_q);
		goal28   = 28'(goal_q);
		step28   = signed'({2'b00, prod_q[25:0]});
		ramp_sum = pres28 + (ramp_up ? step28 : -step28);
		if (ramp_up) begin
			ramp_next = (ramp_sum > goal28) ? goal_q : ramp_sum[SPEED_W-1:0];
		end else if (ramp_dn) begin
			ramp_next = (ramp_sum < goal28) ? goal_q : ramp_sum[SPEED_W-1:0];
		end else begin
			ramp_next = present_q;
		end
	end

	// result
	always_comb begin
		acc_seed = prod_q[23:0] + ANGLE_BIAS;
		q12      = signed'({1'b0, prod_q[45:35]}) - ANGLE_BIAS_Q;
		floor12  = signed'({4'b0000, cfg.floor_angle});
		ceil12   = signed'({4'b0000, cfg.ceil_angle});
		q_clamp  = (q12 < floor12) ? floor12 : q12;
		q_clamp  = (q_clamp > ceil12) ? ceil12 : q_clamp;
		pres_neg = -present_q;
		pres_abs = present_q[SPEED_W-1] ? pres_neg[16:0] : present_q[16:0];
		spd_mag  = prod_q[34:27];
		speed_now = present_q[SPEED_W-1] ? (8'd0 - spd_mag) : spd_mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d   = st_q;
		mul_en = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		unique case (st_q)
			ST_IDLE: begin
				if (in_accept) begin
					st_d = ST_CMD;
				end
			end
			ST_CMD: begin
				if ((in_func_q == FN_TICK) && !in_halt_q) begin
					st_d = ST_RAMP_MUL;
				end else begin
					st_d = ST_ANG_MUL;
				end
			end
			ST_RAMP_MUL: begin
				mul_en = 1'b1;
				mul_a  = signed'({13'd0, rate_sel});
				mul_b  = signed'({8'd0, dt_q});
				st_d   = ST_RAMP_ADD;
			end
			ST_RAMP_ADD: begin
				st_d = ST_ANG_MUL;
			end
			ST_ANG_MUL: begin
				mul_en = 1'b1;
				mul_a  = MUL_A_W'(present_q);
				mul_b  = signed'({21'd0, cfg.span});
				st_d   = ST_ANG_CEN;
			end
			ST_ANG_CEN: begin
				mul_en = 1'b1;
				mul_a  = signed'({15'd0, cfg.center});
				mul_b  = signed'(ANGLE_DIVISOR);
				st_d   = ST_ANG_SUM;
			end
			ST_ANG_SUM: begin
				st_d = ST_ANG_DIV;
			end
			ST_ANG_DIV: begin
				mul_en = 1'b1;
				mul_a  = signed'({1'b0, acc_q});
				mul_b  = signed'({1'b0, DIV5000_M});
				st_d   = ST_SPD_DIV;
			end
			ST_SPD_DIV: begin
				mul_en = 1'b1;
				mul_a  = signed'({6'd0, pres_abs});
				mul_b  = signed'({6'd0, DIV1000_M});
				st_d   = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// latch item, work registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			in_func_q  <= s_tuser;
			in_now_q   <= s_tdata[31:0];
			in_req_q   <= s_tdata[47:32];
			in_dur_q   <= s_tdata[71:48];
			in_halt_q  <= s_tdata[72];
			in_stat_q  <= s_tdata[73];
			in_scene_q <= s_tdata[74];
			in_stick_q <= s_tdata[85:75];
			in_rand_q  <= s_tdata[93:86];
			in_wait_q  <= s_tdata[113:94];
		end
		if (st_q == ST_CMD) begin
			dt_q <= dt_sat;
		end
		if (st_q == ST_ANG_CEN) begin
			acc_q <= acc_seed[21:0];
		end
		if (st_q == ST_ANG_SUM) begin
			acc_q <= acc_q + prod_q[21:0];
		end
		if (st_q == ST_SPD_DIV) begin
			angle_q <= q_clamp[7:0];
		end
		if (out_load) begin
			m_tdata_q <= {speed_now, angle_q};
		end
	end

	// motor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q      <= '0;
			goal_q         <= '0;
			last_tick_q    <= '0;
			wander_due_q   <= '0;
			timed_end_q    <= '0;
			timed_active_q <= 1'b0;
		end else if (st_q == ST_CMD) begin
			case (in_func_q)
				FN_TICK: begin
					last_tick_q <= in_now_q;
					if (in_halt_q) begin
						goal_q         <= '0;
						present_q      <= '0;
						timed_active_q <= 1'b0;
					end else begin
						if (timed_hit) begin
							timed_active_q <= 1'b0;
						end
						if (wander_hit) begin
							goal_q       <= rand_goal;
							wander_due_q <= wander_next;
						end else if (follow) begin
							goal_q <= stick_goal;
						end else if (timed_hit) begin
							goal_q <= '0;
						end
					end
				end
				FN_SET: begin
					goal_q         <= req_goal;
					timed_active_q <= 1'b0;
				end
				FN_TIMED: begin
					goal_q <= req_goal;
					if (in_dur_q != 24'd0) begin
						timed_end_q    <= timed_end_next;
						timed_active_q <= 1'b1;
					end else begin
						timed_active_q <= 1'b0;
					end
				end
				FN_STOP: begin
					goal_q         <= '0;
					present_q      <= '0;
					timed_active_q <= 1'b0;
				end
				FN_INIT: begin
					last_tick_q  <= in_now_q;
					wander_due_q <= init_due;
				end
				default: begin
					goal_q <= goal_q;
				end
			endcase
		end else if (st_q == ST_RAMP_ADD) begin
			present_q <= ramp_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> !s_tready)
		else $error("item accepted while previous item in progress");

	a_present_range: assert property (@(posedge clk) disable iff (!arst_n)
		(present_q <= SPEED_LIMIT) && (present_q >= -SPEED_LIMIT))
		else $error("present speed out of range");

	a_goal_range: assert property (@(posedge clk) disable iff (!arst_n)
		(goal_q <= SPEED_LIMIT) && (goal_q >= -SPEED_LIMIT))
		else $error("goal speed out of range");

	a_angle_ceiling: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_tvalid && (m_tdata[7:0] <= cfg.ceil_angle))
		else $error("servo angle above ceiling");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed ramp servo drive testbench
// Streams command items (tick, set speed, timed set speed, stop, init and
// undefined codes) into the drive and checks every servo angle and integer
// speed against a cycle-free ramp predictor kept in step with each accepted
// item. Runs a directed opening and then random command sequences under several
// register settings, with bursty input traffic and output stalls in most phases.
// ----------------------------------------------------------------------------
module tb_top;
	import srsd_pkg::*;

	localparam int CLK_PERIOD  = 12;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 152;

	typedef struct packed {
		logic [2:0]         func;
		logic [31:0]        now;
		logic signed [15:0] req;
		logic [23:0]        dur;
		logic               halt;
		logic               stationary;
		logic               scene;
		logic signed [10:0] stick;
		logic signed [7:0]  rtarget;
		logic [19:0]        rwait;
	} drive_cmd_t;

	typedef struct packed {
		logic signed [7:0] speed;
		logic [7:0]        angle;
	} drive_out_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [2:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [PADDR_W-1:0]    paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;

	drive_cmd_t pending_cmds[$];
	drive_out_t expected_drive[$];

	srsd_cfg_t   cfg;
	int          present_milli;
	int          goal_milli;
	logic [31:0] last_tick;
	logic [31:0] wander_due;
	logic [31:0] timed_end;
	logic        timed_on;

	logic [31:0] sim_ms;
	int          fail_count = 0;
	int          cycle_count = 0;
	bit          gaps_on = 1'b1;
	bit          stalls_on = 1'b1;
	int          burst_left;
	int          gap_left;
	int          stall_left;

	speed_ramp_servo_drive dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic longint clamp_to(longint v, longint lo, longint hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic bit deadline_passed(logic [31:0] now, logic [31:0] due);
		logic [31:0] diff;
		diff = now - due;
		return !diff[31];
	endfunction

	function automatic void take_request(logic signed [15:0] req);
		goal_milli = int'(clamp_to(longint'(req), -100, 100) * 1000);
		timed_on = 1'b0;
	endfunction

	function automatic drive_out_t predict_drive(drive_cmd_t c);
		logic [31:0] dt;
		longint      step;
		longint      lim;
		longint      tgt;
		longint      num;
		longint      q;
		int          whole;
		drive_out_t  r;
		case (c.func)
			FN_TICK: begin
				dt = c.now - last_tick;
				if (dt > 32'd65535) dt = 32'd65535;
				last_tick = c.now;
				if (c.halt) begin
					goal_milli = 0;
					present_milli = 0;
					timed_on = 1'b0;
				end else begin
					if (timed_on && deadline_passed(c.now, timed_end)) begin
						timed_on = 1'b0;
						goal_milli = 0;
					end
					if (c.stationary && !cfg.wander_en && !c.scene)
						goal_milli = int'(clamp_to(longint'($signed(c.stick)) * 100,
							-100000, 100000));
					if (cfg.wander_en && deadline_passed(c.now, wander_due)) begin
						lim = longint'(cfg.span) * 20;
						tgt = clamp_to(longint'($signed(c.rtarget)), -lim, lim);
						tgt = clamp_to(tgt, -100, 100);
						goal_milli = int'(tgt * 1000);
						wander_due = c.now + {12'd0, c.rwait};
					end
					if (present_milli < goal_milli) begin
						step = longint'(present_milli) + longint'(cfg.accel) * longint'(dt);
						if (step > goal_milli) step = goal_milli;
						present_milli = int'(step);
					end else if (present_milli > goal_milli) begin
						step = longint'(present_milli) - longint'(cfg.decel) * longint'(dt);
						if (step < goal_milli) step = goal_milli;
						present_milli = int'(step);
					end
				end
			end
			FN_SET: begin
				take_request(c.req);
			end
			FN_TIMED: begin
				take_request(c.req);
				if (c.dur != 24'd0) begin
					timed_end = c.now + {8'd0, c.dur};
					timed_on = 1'b1;
				end
			end
			FN_STOP: begin
				goal_milli = 0;
				present_milli = 0;
				timed_on = 1'b0;
			end
			FN_INIT: begin
				last_tick = c.now;
				wander_due = c.now + {24'd0, cfg.first_delay} * 32'd1000;
			end
			default: ;
		endcase
		num = longint'(cfg.center) * 5000 + longint'(present_milli) * longint'(cfg.span);
		q = num / 5000;
		if (num % 5000 != 0 && num < 0) q = q - 1;
		if (q < longint'(cfg.floor_angle)) q = longint'(cfg.floor_angle);
		if (q > longint'(cfg.ceil_angle)) q = longint'(cfg.ceil_angle);
		whole = present_milli / 1000;
		r.angle = q[7:0];
		r.speed = whole[7:0];
		return r;
	endfunction

	function automatic logic [IN_DATA_W-1:0] pack_cmd(drive_cmd_t c);
		return {6'd0, c.rwait, c.rtarget, c.stick, c.scene, c.stationary, c.halt,
			c.dur, c.req, c.now};
	endfunction

	function automatic drive_cmd_t unpack_cmd(logic [IN_DATA_W-1:0] d, logic [2:0] f);
		drive_cmd_t c;
		c.func = f;
		c.now = d[31:0];
		c.req = d[47:32];
		c.dur = d[71:48];
		c.halt = d[72];
		c.stationary = d[73];
		c.scene = d[74];
		c.stick = d[85:75];
		c.rtarget = d[93:86];
		c.rwait = d[113:94];
		return c;
	endfunction

	function automatic drive_cmd_t blank_cmd(logic [2:0] f, logic [31:0] t);
		drive_cmd_t c;
		c = '0;
		c.func = f;
		c.now = t;
		return c;
	endfunction

	function automatic drive_cmd_t random_cmd();
		drive_cmd_t c;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 88)
			sim_ms = sim_ms + $urandom_range(0, 400);
		else if (pick < 97)
			sim_ms = sim_ms + $urandom_range(400, 80000);
		else
			sim_ms = $urandom();
		c = blank_cmd(FN_TICK, sim_ms);
		pick = $urandom_range(0, 99);
		if (pick < 62)
			c.func = FN_TICK;
		else if (pick < 74)
			c.func = FN_SET;
		else if (pick < 86)
			c.func = FN_TIMED;
		else if (pick < 91)
			c.func = FN_STOP;
		else if (pick < 97)
			c.func = FN_INIT;
		else
			c.func = $urandom_range(5, 7);
		if ($urandom_range(0, 99) < 85)
			c.req = $urandom_range(0, 240) - 120;
		else
			c.req = $urandom();
		pick = $urandom_range(0, 99);
		if (pick < 15)
			c.dur = '0;
		else if (pick < 85)
			c.dur = $urandom_range(1, 3000);
		else
			c.dur = $urandom();
		c.halt = ($urandom_range(0, 19) == 0);
		c.stationary = ($urandom_range(0, 2) == 0);
		c.scene = ($urandom_range(0, 3) == 0);
		c.stick = $urandom_range(0, 2000) - 1000;
		c.rtarget = $urandom_range(0, 200) - 100;
		if ($urandom_range(0, 99) < 80)
			c.rwait = $urandom_range(0, 5000);
		else
			c.rwait = $urandom();
		return c;
	endfunction

	task automatic note_failure(string msg);
		if (fail_count < 10) $display("%s", msg);
		fail_count++;
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_CENTER:  cfg.center = v[7:0];
			REG_FLOOR:   cfg.floor_angle = v[7:0];
			REG_CEILING: cfg.ceil_angle = v[7:0];
			REG_SPAN:    cfg.span = v[2:0];
			REG_ACCEL:   cfg.accel = v[9:0];
			REG_DECEL:   cfg.decel = v[9:0];
			REG_WANDER:  cfg.wander_en = v[0];
			REG_DELAY:   cfg.first_delay = v[7:0];
			default: ;
		endcase
	endtask

	task automatic program_setting(int p);
		int center;
		int lo_ang;
		int hi_ang;
		int span;
		int acc;
		int dec;
		int wan;
		int dly;
		center = $urandom_range(0, 180);
		lo_ang = $urandom_range(0, 60);
		hi_ang = $urandom_range(120, 180);
		span = $urandom_range(0, 5);
		acc = $urandom_range(0, 1000);
		dec = $urandom_range(0, 1000);
		wan = $urandom_range(0, 1);
		dly = $urandom_range(0, 10);
		case (p)
			0: begin
				center = 0; lo_ang = 0; hi_ang = 180; span = 0;
				acc = 0; dec = 0; wan = 0; dly = 0;
			end
			1: begin
				center = 180; lo_ang = 180; hi_ang = 180; span = 5;
				acc = 1000; dec = 1000; wan = 1; dly = 255;
			end
			2: begin
				center = 90; lo_ang = 120; hi_ang = 60; span = 5;
				acc = 1; dec = 1000; wan = 1; dly = 0;
			end
			3: begin
				lo_ang = 0; hi_ang = 180; span = 5; wan = 0;
			end
			default: ;
		endcase
		write_reg(REG_CENTER, center);
		write_reg(REG_FLOOR, lo_ang);
		write_reg(REG_CEILING, hi_ang);
		write_reg(REG_SPAN, span);
		write_reg(REG_ACCEL, acc);
		write_reg(REG_DECEL, dec);
		write_reg(REG_WANDER, wan);
		write_reg(REG_DELAY, dly);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (pending_cmds.size() != 0 || s_tvalid || expected_drive.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	// input stream: bursts of items separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		logic next_valid;
		drive_cmd_t item;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else if (!s_tvalid || s_tready) begin
			next_valid = 1'b0;
			if (gap_left > 0) begin
				gap_left = gap_left - 1;
			end else if (pending_cmds.size() > 0) begin
				item = pending_cmds.pop_front();
				s_tdata <= pack_cmd(item);
				s_tuser <= item.func;
				next_valid = 1'b1;
				if (burst_left == 0) burst_left = $urandom_range(1, 24);
				burst_left = burst_left - 1;
				if (burst_left == 0 && gaps_on) gap_left = $urandom_range(0, 12);
			end
			s_tvalid <= next_valid;
		end
	end

	// output stream: random stall stretches
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			stall_left = stall_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (stalls_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 10);
		end
	end

	// check results first, then record the item accepted at this edge
	always @(posedge clk) begin
		drive_out_t want;
		drive_out_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_drive.size() == 0) begin
					note_failure($sformatf("unexpected result: angle %0d speed %0d",
						got.angle, $signed(got.speed)));
				end else begin
					want = expected_drive.pop_front();
					if (got.angle !== want.angle || got.speed !== want.speed)
						note_failure($sformatf(
							"result: expected angle %0d speed %0d, got angle %0d speed %0d",
							want.angle, $signed(want.speed), got.angle, $signed(got.speed)));
				end
			end
			if (s_tvalid && s_tready)
				expected_drive.push_back(predict_drive(unpack_cmd(s_tdata, s_tuser)));
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("speed_ramp_servo_drive: mismatch");
			$finish;
		end
	end

	initial begin
		drive_cmd_t c;
		cfg.center = 8'd90;
		cfg.floor_angle = 8'd0;
		cfg.ceil_angle = 8'd180;
		cfg.span = 3'd3;
		cfg.accel = 10'd100;
		cfg.decel = 10'd100;
		cfg.wander_en = 1'b0;
		cfg.first_delay = 8'd5;
		present_milli = 0;
		goal_milli = 0;
		last_tick = '0;
		wander_due = '0;
		timed_end = '0;
		timed_on = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		pending_cmds.push_back(blank_cmd(FN_INIT, 32'd0));
		c = blank_cmd(FN_SET, 32'd150); c.req = 16'sh7FFF; pending_cmds.push_back(c);
		pending_cmds.push_back(blank_cmd(FN_TICK, 32'd1100));
		c = blank_cmd(FN_SET, 32'd1200); c.req = 16'sh8000; pending_cmds.push_back(c);
		pending_cmds.push_back(blank_cmd(FN_TICK, 32'd80000));
		c = blank_cmd(FN_TIMED, 32'd80010); c.req = 50; pending_cmds.push_back(c);
		pending_cmds.push_back(blank_cmd(FN_TICK, 32'd80500));
		c = blank_cmd(FN_TIMED, 32'd80600); c.req = -50; c.dur = 24'hFFFFFF;
		pending_cmds.push_back(c);
		pending_cmds.push_back(blank_cmd(FN_TICK, 32'd81000));
		c = blank_cmd(FN_TIMED, 32'd81100); c.req = 60; c.dur = 24'd1;
		pending_cmds.push_back(c);
		pending_cmds.push_back(blank_cmd(FN_TICK, 32'd81200));
		c = blank_cmd(FN_TICK, 32'd81300); c.stationary = 1'b1; c.stick = 1000;
		pending_cmds.push_back(c);
		c = blank_cmd(FN_TICK, 32'd82400); c.stationary = 1'b1; c.stick = -1000;
		pending_cmds.push_back(c);
		c = blank_cmd(FN_TICK, 32'd82500); c.stationary = 1'b1; c.scene = 1'b1;
		c.stick = 500;
		pending_cmds.push_back(c);
		c = blank_cmd(FN_TICK, 32'd82600); c.halt = 1'b1; c.stationary = 1'b1;
		c.stick = 700;
		pending_cmds.push_back(c);
		c = blank_cmd(FN_SET, 32'd82700); c.req = 100; pending_cmds.push_back(c);
		pending_cmds.push_back(blank_cmd(FN_TICK, 32'd83000));
		pending_cmds.push_back(blank_cmd(FN_STOP, 32'd83100));
		pending_cmds.push_back(blank_cmd(3'd5, 32'd83200));
		pending_cmds.push_back(blank_cmd(3'd6, 32'd83200));
		pending_cmds.push_back(blank_cmd(3'd7, 32'd83200));
		pending_cmds.push_back(blank_cmd(FN_TICK, 32'hFFFF_FFF0));
		pending_cmds.push_back(blank_cmd(FN_INIT, 32'hFFFF_FFFF));
		c = blank_cmd(FN_SET, 32'hFFFF_FFFF); c.req = -100; pending_cmds.push_back(c);
		pending_cmds.push_back(blank_cmd(FN_TICK, 32'h0000_0010));
		sim_ms = 32'h0000_0010;
		wait_idle();

		for (int p = 0; p < PHASES; p++) begin
			gaps_on = (p != 4);
			stalls_on = (p != 4) && (p != 6);
			program_setting(p);
			if (p == 2) begin
				sim_ms = sim_ms + 32'd100;
				pending_cmds.push_back(blank_cmd(FN_INIT, sim_ms));
				c = blank_cmd(FN_TICK, sim_ms); c.rtarget = 100; c.rwait = 20'hFFFFF;
				c.stationary = 1'b1; c.stick = -1000;
				pending_cmds.push_back(c);
				sim_ms = sim_ms + 32'd2000;
				c = blank_cmd(FN_TICK, sim_ms); c.rtarget = -100;
				pending_cmds.push_back(c);
				sim_ms = sim_ms + 32'd1048575;
				c = blank_cmd(FN_TICK, sim_ms); c.rtarget = -100;
				pending_cmds.push_back(c);
			end
			for (int i = 0; i < PHASE_ITEMS; i++)
				pending_cmds.push_back(random_cmd());
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0 && expected_drive.size() == 0)
			$display("speed_ramp_servo_drive: match");
		else
			$display("speed_ramp_servo_drive: mismatch");
		$finish;
	end

endmodule
